[rtl/smf_pkg.sv]
package smf_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int POOL_DEPTH  = 1024;
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int PA_W        = $clog2(POOL_DEPTH);
  localparam int IDX_W       = 24;
  localparam int VAL_W       = 64;
  localparam int DEPTH_W     = 9;

  localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    K_LOAD = 3'd0,
    K_PUSH = 3'd1,
    K_NEG  = 3'd2,
    K_ADD  = 3'd3,
    K_SUB  = 3'd4,
    K_MUL  = 3'd5,
    K_DIV  = 3'd6,
    K_RET  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fpu_req_t;

  typedef struct packed {
    logic done;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POOL_RD,
    S_POP_RD,
    S_OPA_RD,
    S_FP,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_SPECIAL,
    F_ALIGN,
    F_ADD,
    F_PRE,
    F_MUL,
    F_DIV,
    F_NORM,
    F_ROUND,
    F_DONE
  } fstate_t;

endpackage

[rtl/smf_ram.sv]
module smf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/smf_fpu.sv]
module smf_fpu import smf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fpu_req_t    req,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output fpu_rsp_t    rsp,
  output logic [63:0] result
);

  fstate_t            fst_r, fst_nxt;
  fop_t               op_r, op_nxt;
  logic [63:0]        a_r, a_nxt, b_r, b_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [13:0] ea_r, ea_nxt, eb_r, eb_nxt, e_r, e_nxt;
  logic               sx_r, sx_nxt, sub_r, sub_nxt;
  logic [56:0]        m_r, m_nxt, y_r, y_nxt;
  logic [52:0]        hi_r, hi_nxt, lo_r, lo_nxt;
  logic [53:0]        rem_r, rem_nxt;
  logic [55:0]        q_r, q_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [63:0]        res_r, res_nxt;

  // shared adder
  logic [57:0] alu_x, alu_y, alu_s;
  logic        alu_ci;
  assign alu_s = alu_x + alu_y + {57'b0, alu_ci};

  logic               sa, sb, nan_a, nan_b, inf_a, inf_b, z_a, z_b, big_a;
  logic [52:0]        mant_a, mant_b;
  logic signed [13:0] exp_a, exp_b, dexp;
  logic [105:0]       prod;
  logic               inc, ge;
  logic [63:0]        inf_x, zero_x;

  always_comb begin
    sa     = a_r[63];
    sb     = b_r[63];
    nan_a  = (&a_r[62:52]) && (|a_r[51:0]);
    nan_b  = (&b_r[62:52]) && (|b_r[51:0]);
    inf_a  = (&a_r[62:52]) && !(|a_r[51:0]);
    inf_b  = (&b_r[62:52]) && !(|b_r[51:0]);
    z_a    = !(|a_r[62:0]);
    z_b    = !(|b_r[62:0]);
    big_a  = a_r[62:0] >= b_r[62:0];
    mant_a = {|a_r[62:52], a_r[51:0]};
    mant_b = {|b_r[62:52], b_r[51:0]};
    exp_a  = (|a_r[62:52]) ? {3'b0, a_r[62:52]} : 14'sd1;
    exp_b  = (|b_r[62:52]) ? {3'b0, b_r[62:52]} : 14'sd1;
    dexp   = big_a ? (exp_a - exp_b) : (exp_b - exp_a);
    inf_x  = {sa ^ sb, 11'h7FF, 52'b0};
    zero_x = {sa ^ sb, 63'b0};
    prod   = {hi_r, lo_r};
    inc    = m_r[2] & (m_r[3] | m_r[1] | m_r[0]);
    ge     = !alu_s[57];
  end

  always_comb begin
    fst_nxt = fst_r;
    op_nxt  = op_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    ea_nxt  = ea_r;
    eb_nxt  = eb_r;
    e_nxt   = e_r;
    sx_nxt  = sx_r;
    sub_nxt = sub_r;
    m_nxt   = m_r;
    y_nxt   = y_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    alu_x   = '0;
    alu_y   = '0;
    alu_ci  = 1'b0;
    rsp     = '0;

    unique case (fst_r)
      F_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          a_nxt   = opa;
          b_nxt   = (req.op == FOP_SUB) ? (opb ^ SIGN_BIT) : opb;
          fst_nxt = F_SPECIAL;
        end
      end

      F_SPECIAL: begin
        fst_nxt = F_DONE;
        if (nan_a || nan_b) begin
          res_nxt = QNAN;
        end else begin
          case (op_r) inside
            FOP_ADD, FOP_SUB: begin
              if (inf_a && inf_b) begin
                res_nxt = (sa == sb) ? a_r : QNAN;
              end else if (inf_a) begin
                res_nxt = a_r;
              end else if (inf_b) begin
                res_nxt = b_r;
              end else if (z_a && z_b) begin
                res_nxt = {sa & sb, 63'b0};
              end else if (z_a) begin
                res_nxt = b_r;
              end else if (z_b) begin
                res_nxt = a_r;
              end else begin
                sx_nxt  = big_a ? sa : sb;
                sub_nxt = sa ^ sb;
                m_nxt   = {1'b0, big_a ? mant_a : mant_b, 3'b0};
                y_nxt   = {1'b0, big_a ? mant_b : mant_a, 3'b0};
                e_nxt   = big_a ? exp_a : exp_b;
                // far smaller operand only leaves a sticky bit
                if (dexp > 14'sd58) begin
                  y_nxt   = 57'd1;
                  cnt_nxt = '0;
                end else begin
                  cnt_nxt = dexp[5:0];
                end
                fst_nxt = F_ALIGN;
              end
            end
            FOP_MUL: begin
              if ((inf_a && z_b) || (z_a && inf_b)) begin
                res_nxt = QNAN;
              end else if (inf_a || inf_b) begin
                res_nxt = inf_x;
              end else if (z_a || z_b) begin
                res_nxt = zero_x;
              end else begin
                sx_nxt  = sa ^ sb;
                ma_nxt  = mant_a;
                mb_nxt  = mant_b;
                ea_nxt  = exp_a;
                eb_nxt  = exp_b;
                fst_nxt = F_PRE;
              end
            end
            default: begin
              if (z_b) begin
                res_nxt = z_a ? QNAN : inf_x;
              end else if (inf_a) begin
                res_nxt = inf_b ? QNAN : inf_x;
              end else if (inf_b || z_a) begin
                res_nxt = zero_x;
              end else begin
                sx_nxt  = sa ^ sb;
                ma_nxt  = mant_a;
                mb_nxt  = mant_b;
                ea_nxt  = exp_a;
                eb_nxt  = exp_b;
                fst_nxt = F_PRE;
              end
            end
          endcase
        end
      end

      F_ALIGN: begin
        if (cnt_r != '0) begin
          y_nxt   = {1'b0, y_r[56:2], y_r[1] | y_r[0]};
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          fst_nxt = F_ADD;
        end
      end

      F_ADD: begin
        alu_x   = {1'b0, m_r};
        alu_y   = sub_r ? ~{1'b0, y_r} : {1'b0, y_r};
        alu_ci  = sub_r;
        m_nxt   = alu_s[56:0];
        fst_nxt = F_NORM;
      end

      F_PRE: begin
        // subnormal operands get a leading one first
        if (!ma_r[52]) begin
          ma_nxt = {ma_r[51:0], 1'b0};
          ea_nxt = ea_r - 14'sd1;
        end else if (!mb_r[52]) begin
          mb_nxt = {mb_r[51:0], 1'b0};
          eb_nxt = eb_r - 14'sd1;
        end else if (op_r == FOP_MUL) begin
          hi_nxt  = '0;
          lo_nxt  = mb_r;
          cnt_nxt = 6'd53;
          fst_nxt = F_MUL;
        end else begin
          rem_nxt = {1'b0, ma_r};
          q_nxt   = '0;
          cnt_nxt = 6'd56;
          fst_nxt = F_DIV;
        end
      end

      F_MUL: begin
        alu_x = {5'b0, hi_r};
        alu_y = {5'b0, lo_r[0] ? ma_r : 53'b0};
        if (cnt_r != '0) begin
          hi_nxt  = alu_s[53:1];
          lo_nxt  = {alu_s[0], lo_r[52:1]};
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          m_nxt   = {1'b0, prod[105:51], prod[50] | (|prod[49:0])};
          e_nxt   = ea_r + eb_r - 14'sd1022;
          fst_nxt = F_NORM;
        end
      end

      F_DIV: begin
        alu_x  = {4'b0, rem_r};
        alu_y  = ~{5'b0, mb_r};
        alu_ci = 1'b1;
        if (cnt_r != '0) begin
          rem_nxt = ge ? {alu_s[52:0], 1'b0} : {rem_r[52:0], 1'b0};
          q_nxt   = {q_r[54:0], ge};
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          m_nxt   = {1'b0, q_r[55:1], q_r[0] | (|rem_r)};
          e_nxt   = ea_r - eb_r + 14'sd1023;
          fst_nxt = F_NORM;
        end
      end

      F_NORM: begin
        if (m_r[56] || (e_r < 14'sd1)) begin
          if (e_r < -14'sd60) begin
            m_nxt = {56'b0, |m_r};
            e_nxt = 14'sd1;
          end else begin
            m_nxt = {1'b0, m_r[56:2], m_r[1] | m_r[0]};
            e_nxt = e_r + 14'sd1;
          end
        end else if (!m_r[55] && (e_r > 14'sd1) && (|m_r)) begin
          m_nxt = {m_r[55:0], 1'b0};
          e_nxt = e_r - 14'sd1;
        end else begin
          fst_nxt = F_ROUND;
        end
      end

      F_ROUND: begin
        alu_x = {5'b0, m_r[55:3]};
        alu_y = {57'b0, inc};
        if (m_r == '0) begin
          res_nxt = '0;
        end else if (e_r > 14'sd2046) begin
          res_nxt = {sx_r, 11'h7FF, 52'b0};
        end else if (alu_s[53]) begin
          res_nxt = {sx_r, e_r[10:0] + 11'd1, 52'b0};
        end else begin
          res_nxt = {sx_r, alu_s[52] ? e_r[10:0] : 11'd0, alu_s[51:0]};
        end
        fst_nxt = F_DONE;
      end

      F_DONE: begin
        rsp.done = 1'b1;
        fst_nxt  = F_IDLE;
      end

      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    ea_r  <= ea_nxt;
    eb_r  <= eb_nxt;
    e_r   <= e_nxt;
    sx_r  <= sx_nxt;
    sub_r <= sub_nxt;
    m_r   <= m_nxt;
    y_r   <= y_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

[rtl/stack_machine_float_evaluator_top.sv]
// Stack-machine evaluator on IEEE doubles. Each input word is one decoded
// instruction and gives exactly one output word with status, stack top,
// depth and a finished flag. The top of stack lives in a register, the rest
// of the stack and the constant pool sit in single-port-read RAMs. Add, sub,
// mul and div run on one shared iterative floating-point unit (one adder
// reused for addition, shift-add multiply, restoring divide and rounding):
// add and sub take longer with a larger exponent gap and with cancellation,
// mul and div with subnormal results or subnormal operands. One instruction
// is in flight at a time; the next one is taken while the previous result
// word waits at the output.
module stack_machine_float_evaluator_top import smf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [IDX_W-1:0]   in_const_index,
  input  logic [VAL_W-1:0]   in_const_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [VAL_W-1:0]   out_top_value,
  output logic [DEPTH_W-1:0] out_depth,
  output logic               out_finished
);

  state_t             st_r, st_nxt;
  kind_t              kind_r, kind_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [VAL_W-1:0]   top_r, top_nxt, rep_r, rep_nxt;
  logic               fin_r, fin_nxt;
  status_t            stat_r, stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic               out_fin_r, out_fin_nxt;

  logic               pool_we;
  logic [PA_W-1:0]    pool_raddr;
  logic [VAL_W-1:0]   pool_rdata;
  logic               stk_we;
  logic [SA_W-1:0]    stk_waddr, stk_raddr;
  logic [VAL_W-1:0]   stk_rdata;

  fpu_req_t           fpu_req;
  fpu_rsp_t           fpu_rsp;
  logic [VAL_W-1:0]   fpu_res;

  logic               in_take, idx_ok;

  smf_ram #(.WIDTH(VAL_W), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (idx_r[PA_W-1:0]),
    .wdata (val_r),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  // holds every entry below the top
  smf_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (top_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  smf_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fpu_req),
    .opa    (stk_rdata),
    .opb    (top_r),
    .rsp    (fpu_rsp),
    .result (fpu_res)
  );

  assign in_stall = (st_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign idx_ok   = {1'b0, idx_r} < (IDX_W + 1)'(POOL_DEPTH);

  always_comb begin
    st_nxt         = st_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    sp_nxt         = sp_r;
    top_nxt        = top_r;
    rep_nxt        = rep_r;
    fin_nxt        = fin_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_fin_nxt    = out_fin_r;
    pool_we        = 1'b0;
    pool_raddr     = idx_r[PA_W-1:0];
    stk_we         = 1'b0;
    stk_waddr      = SA_W'(sp_r - SP_W'(1));
    stk_raddr      = SA_W'(sp_r - SP_W'(2));
    fpu_req        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_take) begin
          kind_nxt = kind_t'(in_kind);
          idx_nxt  = in_const_index;
          val_nxt  = in_const_value;
          fin_nxt  = 1'b0;
          stat_nxt = ST_OK;
          st_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        st_nxt = S_DONE;
        unique case (kind_r)
          K_LOAD: begin
            if (!idx_ok) begin
              stat_nxt = ST_INDEX;
            end else begin
              pool_we = 1'b1;
            end
          end
          K_PUSH: begin
            if (!idx_ok) begin
              stat_nxt = ST_INDEX;
            end else if (sp_r == SP_W'(STACK_DEPTH)) begin
              stat_nxt = ST_OVER;
            end else begin
              st_nxt = S_POOL_RD;
            end
          end
          K_NEG: begin
            if (sp_r == '0) begin
              stat_nxt = ST_UNDER;
            end else begin
              top_nxt = top_r ^ SIGN_BIT;
            end
          end
          K_RET: begin
            if (sp_r == '0) begin
              stat_nxt = ST_UNDER;
            end else begin
              rep_nxt = top_r;
              fin_nxt = 1'b1;
              sp_nxt  = sp_r - SP_W'(1);
              if (sp_r >= SP_W'(2)) begin
                st_nxt = S_POP_RD;
              end
            end
          end
          default: begin
            if (sp_r < SP_W'(2)) begin
              stat_nxt = ST_UNDER;
            end else begin
              st_nxt = S_OPA_RD;
            end
          end
        endcase
      end

      S_POOL_RD: begin
        // old top moves down into the ram
        stk_we  = (sp_r != '0);
        top_nxt = pool_rdata;
        sp_nxt  = sp_r + SP_W'(1);
        st_nxt  = S_DONE;
      end

      S_POP_RD: begin
        top_nxt = stk_rdata;
        st_nxt  = S_DONE;
      end

      S_OPA_RD: begin
        fpu_req.start = 1'b1;
        unique case (kind_r)
          K_ADD:   fpu_req.op = FOP_ADD;
          K_SUB:   fpu_req.op = FOP_SUB;
          K_MUL:   fpu_req.op = FOP_MUL;
          default: fpu_req.op = FOP_DIV;
        endcase
        st_nxt = S_FP;
      end

      S_FP: begin
        if (fpu_rsp.done) begin
          top_nxt = fpu_res;
          sp_nxt  = sp_r - SP_W'(1);
          st_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_top_nxt    = fin_r ? rep_r : ((sp_r == '0) ? '0 : top_r);
          out_depth_nxt  = DEPTH_W'(sp_r);
          out_fin_nxt    = fin_r;
          st_nxt         = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    top_r        <= top_nxt;
    rep_r        <= rep_nxt;
    fin_r        <= fin_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_fin_r    <= out_fin_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_finished  = out_fin_r;

`ifndef SYNTH
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_status == ST_OK))
    else $error("finished word with error status");

  a_fpu_done: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_rsp.done |-> (st_r == S_FP))
    else $error("fpu result outside arithmetic wait");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after taking a word");
`endif

endmodule

[tb/sv/tb.sv]
module tb;
  import smf_pkg::*;

  localparam int LIMIT     = 1_500_000;
  localparam int N_RANDOM  = 860;
  localparam int N_QUIET   = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] top;
    logic [8:0]  depth;
    logic        fin;
  } word_t;

  typedef struct {
    kind_t       k;
    logic [23:0] idx;
    logic [63:0] val;
    bit          typed;
    word_t       w;
  } row_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         in_kind = K_LOAD;
  logic [IDX_W-1:0]   in_const_index = '0;
  logic [VAL_W-1:0]   in_const_value = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         out_status;
  logic [VAL_W-1:0]   out_top_value;
  logic [DEPTH_W-1:0] out_depth;
  logic               out_finished;

  stack_machine_float_evaluator_top DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // shadow machine state
  logic [63:0] stk [STACK_DEPTH];
  logic [63:0] pool [POOL_DEPTH];
  bit          pool_ok [POOL_DEPTH];
  int          loaded_idx [$];
  int          sp = 0;

  word_t  pending_words [$];
  row_t   rows [$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 0;
  int     stall_left = 0;

  function automatic bit is_nan(logic [63:0] b);
    return b[62:52] == 11'h7FF && b[51:0] != 0;
  endfunction

  function automatic logic [63:0] quieten(logic [63:0] b);
    return is_nan(b) ? QNAN : b;
  endfunction

  function automatic logic [63:0] float_op(kind_t k, logic [63:0] a, logic [63:0] b);
    real x, y;
    x = $bitstoreal(a);
    y = $bitstoreal(b);
    case (k)
      K_ADD: return quieten($realtobits(x + y));
      K_SUB: return quieten($realtobits(x - y));
      K_MUL: return quieten($realtobits(x * y));
      default: begin
        if (b[62:0] == 0) begin
          if (is_nan(a) || a[62:0] == 0) return QNAN;
          return {a[63] ^ b[63], 11'h7FF, 52'd0};
        end
        return quieten($realtobits(x / y));
      end
    endcase
  endfunction

  // advance the shadow machine by one instruction and give its result word
  function automatic word_t execute(kind_t k, logic [23:0] idx, logic [63:0] val);
    word_t w;
    bit popped;
    w = '0;
    popped = 0;
    case (k)
      K_LOAD:
        if (idx >= POOL_DEPTH) w.status = ST_INDEX;
        else begin
          pool[idx] = val;
          if (!pool_ok[idx]) loaded_idx.push_back(idx);
          pool_ok[idx] = 1;
        end
      K_PUSH:
        if (idx >= POOL_DEPTH) w.status = ST_INDEX;
        else if (sp >= STACK_DEPTH) w.status = ST_OVER;
        else begin
          stk[sp] = pool[idx];
          sp++;
        end
      K_NEG:
        if (sp < 1) w.status = ST_UNDER;
        else stk[sp-1] = stk[sp-1] ^ SIGN_BIT;
      K_RET:
        if (sp < 1) w.status = ST_UNDER;
        else begin
          w.top = stk[sp-1];
          sp--;
          w.fin = 1;
          popped = 1;
        end
      default:
        if (sp < 2) w.status = ST_UNDER;
        else begin
          stk[sp-2] = float_op(k, stk[sp-2], stk[sp-1]);
          sp--;
        end
    endcase
    if (!popped) w.top = (sp > 0) ? stk[sp-1] : 64'd0;
    w.depth = sp[8:0];
    return w;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 40) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  task automatic send(kind_t k, logic [23:0] idx, logic [63:0] val,
                      bit typed = 0, word_t tw = '0);
    int gap;
    word_t w;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1;
    in_kind        <= k;
    in_const_index <= idx;
    in_const_value <= val;
    do @(posedge clk); while (in_stall);
    w = execute(k, idx, val);
    pending_words.push_back(typed ? tw : w);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] specials [8];
    logic [51:0] mant;
    logic        sgn;
    specials = '{64'd0, SIGN_BIT, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 QNAN, 64'h7FF0_0000_0000_0001, 64'h0000_0000_0000_0001,
                 64'h7FEF_FFFF_FFFF_FFFF};
    mant = {20'($urandom_range(0, 20'hFFFFF)), $urandom};
    sgn  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: return specials[$urandom_range(0, 7)];
      1: return {$urandom, $urandom};
      2: return {sgn, 11'd0, mant};
      3: return {sgn, 11'h7F0 + 11'($urandom_range(0, 14)), mant};
      default: return {sgn, 11'h3F0 + 11'($urandom_range(0, 31)), mant};
    endcase
  endfunction

  task automatic random_instr();
    int r;
    kind_t k;
    logic [23:0] idx;
    logic [63:0] val;
    r   = $urandom_range(0, 99);
    idx = 24'($urandom_range(0, 24'hFFFFFF));
    val = {$urandom, $urandom};
    if (r < 12) begin
      k = K_LOAD;
      idx = 24'($urandom_range(0, POOL_DEPTH - 1));
      val = pick_value();
    end else if (r < 15) begin
      k = r[0] ? K_LOAD : K_PUSH;
      idx = 24'($urandom_range(POOL_DEPTH, 24'hFFFFFF));
    end else if (r < 45 && sp < 20) begin
      k = K_PUSH;
      idx = 24'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
    end else if (r < 52) begin
      k = K_NEG;
    end else if (r < 90) begin
      k = kind_t'(K_ADD + $urandom_range(0, 3));
    end else begin
      k = K_RET;
    end
    send(k, idx, val);
  endtask

  function automatic word_t wd(status_t s, logic [63:0] t, int d, bit f);
    return '{status: s, top: t, depth: 9'(d), fin: f};
  endfunction

  task automatic row(kind_t k, logic [23:0] idx, logic [63:0] val,
                     bit typed = 0, word_t w = '0);
    rows.push_back('{k: k, idx: idx, val: val, typed: typed, w: w});
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", 64'd0, out_top_value);
      end else begin
        e = pending_words.pop_front();
        if (out_status !== e.status) report("status", 64'(e.status), 64'(out_status));
        if (out_top_value !== e.top) report("top_value", e.top, out_top_value);
        if (out_depth !== e.depth) report("depth", 64'(e.depth), 64'(out_depth));
        if (out_finished !== e.fin) report("finished", 64'(e.fin), 64'(out_finished));
      end
    end
  end

  initial begin
    foreach (pool_ok[i]) pool_ok[i] = 0;

    // error paths on an empty machine, then pool loads and special-value arithmetic
    row(K_NEG,  0, 0, 1, wd(ST_UNDER, 0, 0, 0));
    row(K_RET,  0, 0, 1, wd(ST_UNDER, 0, 0, 0));
    row(K_SUB,  0, 0, 1, wd(ST_UNDER, 0, 0, 0));
    row(K_LOAD, 1024, 64'h1234, 1, wd(ST_INDEX, 0, 0, 0));
    row(K_LOAD, 24'hFFFFFF, '1, 1, wd(ST_INDEX, 0, 0, 0));
    row(K_PUSH, 24'hFFFFFF, 0, 1, wd(ST_INDEX, 0, 0, 0));
    row(K_LOAD, 0, '1, 1, wd(ST_OK, 0, 0, 0));
    row(K_LOAD, 1023, 0, 1, wd(ST_OK, 0, 0, 0));
    row(K_LOAD, 1, 64'h4008_0000_0000_0000, 1, wd(ST_OK, 0, 0, 0));
    row(K_LOAD, 2, SIGN_BIT, 1, wd(ST_OK, 0, 0, 0));
    row(K_LOAD, 3, 64'h7FF0_0000_0000_0000, 1, wd(ST_OK, 0, 0, 0));
    row(K_LOAD, 4, 64'h0000_0000_0000_0001, 1, wd(ST_OK, 0, 0, 0));
    row(K_PUSH, 1023, 0, 1, wd(ST_OK, 0, 1, 0));
    row(K_MUL,  0, 0, 1, wd(ST_UNDER, 0, 1, 0));
    row(K_PUSH, 1, 0, 1, wd(ST_OK, 64'h4008_0000_0000_0000, 2, 0));
    row(K_DIV,  0, 0);
    row(K_PUSH, 1023, 0);
    row(K_DIV,  0, 0);     // zero over zero
    row(K_PUSH, 0, 0);
    row(K_NEG,  0, 0);     // nan keeps its payload
    row(K_ADD,  0, 0);
    row(K_PUSH, 3, 0);
    row(K_SUB,  0, 0);
    row(K_PUSH, 1, 0);
    row(K_PUSH, 2, 0);
    row(K_DIV,  0, 0);     // divide by negative zero
    row(K_PUSH, 4, 0);
    row(K_MUL,  0, 0);
    row(K_RET,  0, 0);
    row(K_RET,  0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    foreach (rows[i]) send(rows[i].k, rows[i].idx, rows[i].val, rows[i].typed, rows[i].w);

    // fill the stack past the top to hit overflow
    while (sp < STACK_DEPTH)
      send(K_PUSH, 24'(loaded_idx[$urandom_range(0, loaded_idx.size()-1)]), 0);
    send(K_PUSH, 1, 0);
    send(K_PUSH, 4, 0);
    send(K_ADD, 0, 0);
    @(negedge clk);
    in_valid <= 0;
    while (pending_words.size() != 0) @(posedge clk);
    while (sp > 0) send(sp[0] ? K_RET : K_MUL, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1;
      random_instr();
    end
    @(negedge clk);
    in_valid <= 0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
